// ----- rtl/bra_pkg.sv -----
package bra_pkg;

  // Fixed field widths of the request and result beats.
  localparam int ID_W     = 32;
  localparam int SIZE_W   = 7;
  localparam int LEN_W    = 7;
  localparam int TYPE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int REL_W    = 6;

  // Default configuration of the block.
  localparam int BRA_MAX_SLOTS   = 64;
  localparam int BRA_QUEUE_DEPTH = 2;
  localparam logic [SIZE_W-1:0] DOMAIN_SIZE_RESET = 7'd64;

  // Request types.
  localparam logic [TYPE_W-1:0] REQ_CLAIM   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_SHARE   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NODOM    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ID     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_SIZE = 2'd2;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [STATUS_W-1:0] pre;
    logic [TYPE_W-1:0]   kind;
    logic [REL_W-1:0]    rel;
    logic [LEN_W-1:0]    len;
  } cmd_t;

endpackage

// ----- rtl/bra_queue.sv -----
module bra_queue import bra_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = BRA_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = slots[rd_ptr];

  // Storage of the waiting beats.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/bra_front.sv -----
module bra_front import bra_pkg::*; #(
  parameter int MAX_SLOTS = BRA_MAX_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]      cfg_data,
  input  logic [TYPE_W-1:0]    req_type,
  input  logic [ID_W-1:0]      domain_sel,
  input  logic [ID_W-1:0]      first_id,
  input  logic [LEN_W-1:0]     range_len,
  output cmd_t                 cmd
);

  logic [ID_W-1:0]   domain_id;
  logic [ID_W-1:0]   base_id;
  logic [SIZE_W-1:0] domain_size;
  logic [SIZE_W-1:0] size_eff;
  logic [ID_W-1:0]   rel_full;
  logic [ID_W:0]     end_full;
  logic              range_bad;

  assign cfg_ready = 1'b1;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      domain_id   <= '0;
      base_id     <= '0;
      domain_size <= DOMAIN_SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DOMAIN_ID:   domain_id   <= cfg_data;
        CFG_BASE_ID:     base_id     <= cfg_data;
        CFG_DOMAIN_SIZE: domain_size <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Range check against the clamped domain size.
  assign size_eff  = (domain_size > SIZE_W'(MAX_SLOTS)) ? SIZE_W'(MAX_SLOTS) : domain_size;
  assign rel_full  = first_id - base_id;
  assign end_full  = {1'b0, rel_full} + (ID_W + 1)'(range_len);
  assign range_bad = (first_id < base_id) || (range_len == '0) ||
                     (rel_full >= ID_W'(size_eff)) ||
                     (end_full > (ID_W + 1)'(size_eff));

  // Classification in check order: domain, range, request type.
  always_comb begin
    cmd.kind = req_type;
    cmd.rel  = rel_full[REL_W-1:0];
    cmd.len  = range_len;
    if (domain_sel != domain_id) begin
      cmd.pre = ST_NODOM;
    end else if (range_bad) begin
      cmd.pre = ST_RANGE;
    end else if (req_type != REQ_CLAIM && req_type != REQ_RELEASE &&
                 req_type != REQ_SHARE) begin
      cmd.pre = ST_RANGE;
    end else begin
      cmd.pre = ST_DONE;
    end
  end

endmodule

// ----- rtl/bra_back.sv -----
module bra_back import bra_pkg::*; #(
  parameter int MAX_SLOTS = BRA_MAX_SLOTS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_empty,
  output logic                            cmd_pop,
  input  cmd_t                            cmd,
  input  logic                            res_full,
  output logic                            res_push,
  output logic [STATUS_W+2*MAX_SLOTS-1:0] res_data
);

  logic [MAX_SLOTS-1:0] free_bits;
  logic [MAX_SLOTS-1:0] shared_bits;
  logic [MAX_SLOTS-1:0] free_bits_next;
  logic [MAX_SLOTS-1:0] shared_bits_next;
  logic [MAX_SLOTS-1:0] span;
  logic [MAX_SLOTS-1:0] own;
  logic [MAX_SLOTS-1:0] want;
  logic [STATUS_W-1:0]  status;

  assign cmd_pop  = ~cmd_empty & ~res_full;
  assign res_push = cmd_pop;

  // Slot mask of the range; the front has already bounded it to the domain.
  assign span = (~({MAX_SLOTS{1'b1}} << cmd.len)) << cmd.rel;
  assign own  = span & ~shared_bits;
  assign want = (cmd.kind == REQ_CLAIM) ? own : '0;

  // Conflict check and bitmap update.
  always_comb begin
    free_bits_next   = free_bits;
    shared_bits_next = shared_bits;
    status           = cmd.pre;
    if (cmd.pre == ST_DONE) begin
      if (cmd.kind == REQ_SHARE) begin
        if (((free_bits & span) != span) || ((shared_bits & span) != '0)) begin
          status = ST_CONFLICT;
        end else begin
          shared_bits_next = shared_bits | span;
        end
      end else begin
        if ((free_bits & own) != want) begin
          status = ST_CONFLICT;
        end else begin
          free_bits_next = free_bits ^ own;
        end
      end
    end
  end

  assign res_data = {status, free_bits_next, shared_bits_next};

  // Bitmaps advance once per executed beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_bits   <= '0;
      shared_bits <= '0;
    end else if (cmd_pop) begin
      free_bits   <= free_bits_next;
      shared_bits <= shared_bits_next;
    end
  end

endmodule

// ----- rtl/bitmap_range_resource_allocator.sv -----
// A request is registered into the command queue, and its result, after the bitmap update,
// is registered into the result queue, which drives the ports.
// Throughput: one request per cycle; the read-modify-write of the two
// bitmaps in the back end sets that figure, and each side stalls only when its queue fills.
// Reset (rst, synchronous): both bitmaps clear, both queues empty, configuration to defaults.
module bitmap_range_resource_allocator import bra_pkg::*; #(
  parameter int MAX_SLOTS   = BRA_MAX_SLOTS,
  parameter int QUEUE_DEPTH = BRA_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]      cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [TYPE_W-1:0]    req_type,
  input  logic [ID_W-1:0]      domain_sel,
  input  logic [ID_W-1:0]      first_id,
  input  logic [LEN_W-1:0]     range_len,
  output logic                 empty,
  input  logic                 pop,
  output logic [STATUS_W-1:0]  status,
  output logic [MAX_SLOTS-1:0] avail_mask,
  output logic [MAX_SLOTS-1:0] share_mask
);

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = STATUS_W + 2 * MAX_SLOTS;

  cmd_t             cmd_in;
  logic [CMD_W-1:0] cmd_raw;
  cmd_t             cmd_out;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_full;
  logic             res_push;
  logic [RES_W-1:0] res_in;
  logic [RES_W-1:0] res_out;

  // Front end: configuration and request classification.
  bra_front #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_type(req_type),
    .domain_sel(domain_sel),
    .first_id(first_id),
    .range_len(range_len),
    .cmd(cmd_in)
  );

  // Queue of classified requests.
  bra_queue #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .din(cmd_in),
    .pop(cmd_pop),
    .empty(cmd_empty),
    .dout(cmd_raw)
  );

  assign cmd_out = cmd_t'(cmd_raw);

  // Back end: conflict check and bitmap update.
  bra_back #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_empty(cmd_empty),
    .cmd_pop(cmd_pop),
    .cmd(cmd_out),
    .res_full(res_full),
    .res_push(res_push),
    .res_data(res_in)
  );

  // Queue of result beats toward the consumer.
  bra_queue #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk(clk),
    .rst(rst),
    .push(res_push),
    .full(res_full),
    .din(res_in),
    .pop(pop),
    .empty(empty),
    .dout(res_out)
  );

  assign status     = res_out[RES_W-1 -: STATUS_W];
  assign avail_mask = res_out[2*MAX_SLOTS-1 -: MAX_SLOTS];
  assign share_mask = res_out[MAX_SLOTS-1:0];

endmodule
